// File: src/mvw_pkg.sv
// ----------------------------------------------------------------------------
// mvw_pkg
// Shared types and constants for the mesh vertex welder: beat layouts,
// item modes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package mvw_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = IDX_W + 1;

	// configuration port
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int TOL_W        = 31;
	localparam int REG_IDX_W    = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WELD_TOLERANCE = REG_IDX_W'(0);
	localparam logic [TOL_W-1:0]     TOL_RESET          = TOL_W'(6554);

	typedef enum logic [1:0] {
		MODE_BEGIN  = 2'd0,
		MODE_VERTEX = 2'd1,
		MODE_TRI    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NO_CORNER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_TRI,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [9:0]         corner_a;
		logic [9:0]         corner_b;
		logic [9:0]         corner_c;
	} item_t;

	typedef struct packed {
		logic [9:0] weld_index;
		logic       is_new;
		logic [9:0] mapped_a;
		logic [9:0] mapped_b;
		logic [9:0] mapped_c;
		logic       keep_triangle;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_t;

endpackage

// File: src/mesh_vertex_welder_core.sv
// ----------------------------------------------------------------------------
// mesh_vertex_welder_core
// Vertex welder: one shared three-axis tolerance compare walks the unique
// vertex store under a small sequencer; a remap table resolves triangles.
// ----------------------------------------------------------------------------
// Usage:
//   item / item_valid / item_stall carry one begin, vertex or triangle beat;
//   result / result_valid / result_stall return exactly one beat per item.
//   Configure weld_tolerance over the APB port (byte address 0) while idle.
// Sequence per item (from accept to result_valid, receiver not stalling):
//   begin, unused mode, capacity or corner error: straight to S_DONE.
//   vertex: S_SEARCH walks the store from entry 0 and stops at the first
//   hit or after the last stored entry. The compare unit checks one stored
//   vertex per cycle, fed by a registered read of the unique store.
//   triangle: S_TRI, three reads of the single remap table port.
//   item_stall is high from accept until the result is moved to the output
//   register.
// Reset: counts cleared, tolerance back to its default, output empty. The
//   stores are not cleared; a begin beat only rewinds the counts.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile, and its result holds in the sequencer until the output
//   beat is taken.
// ----------------------------------------------------------------------------
module mesh_vertex_welder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mvw_pkg::item_t                    item,
	input  logic                              item_valid,
	output logic                              item_stall,
	output mvw_pkg::result_t                  result,
	output logic                              result_valid,
	input  logic                              result_stall,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mvw_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [mvw_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [mvw_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import mvw_pkg::*;

	state_t            state_q, state_d;
	logic [TOL_W-1:0]  tol_q;
	logic [CNT_W-1:0]  recv_cnt_q, uniq_cnt_q;
	vertex_t           crd_q;
	logic [IDX_W-1:0]  cor_a_q, cor_b_q, cor_c_q;
	result_t           res_q;
	result_t           acc_res;
	result_t           result_q;
	logic              result_valid_q;

	// search pipe
	logic [CNT_W-1:0]  rd_k_q;
	logic [IDX_W-1:0]  cmp_k_q;
	logic              cmp_valid_q;
	vertex_t           uniq_rd_q;
	logic [1:0]        tri_step_q;

	vertex_t           uniq_mem [MAX_VERTICES];
	logic [IDX_W-1:0]  remap_mem [MAX_VERTICES];
	logic [IDX_W-1:0]  remap_rd_q;

	logic              accept, cfg_wr, out_load;
	logic              issue, hit, search_end, full, corner_bad;
	logic              uniq_we, remap_we;
	logic [IDX_W-1:0]  remap_wdata, remap_raddr;

	function automatic logic axis_close(logic signed [31:0] a, logic signed [31:0] b,
			logic [TOL_W-1:0] tol);
		logic signed [32:0] d;
		logic [32:0]        mag;
		d   = 33'(a) - 33'(b);
		mag = d[32] ? 33'(-d) : 33'(d);
		return mag <= {2'b00, tol};
	endfunction

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1:2] == REG_WELD_TOLERANCE);
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_WELD_TOLERANCE)
		? {1'b0, tol_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// ---------------- sequencer ----------------
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign full       = (recv_cnt_q == CNT_W'(MAX_VERTICES));
	assign corner_bad = ({1'b0, item.corner_a} >= recv_cnt_q)
		|| ({1'b0, item.corner_b} >= recv_cnt_q)
		|| ({1'b0, item.corner_c} >= recv_cnt_q);

	assign issue = (rd_k_q < uniq_cnt_q);
	assign hit   = cmp_valid_q && axis_close(uniq_rd_q.x, crd_q.x, tol_q)
		&& axis_close(uniq_rd_q.y, crd_q.y, tol_q)
		&& axis_close(uniq_rd_q.z, crd_q.z, tol_q);
	// nothing left in flight and the last compare missed
	assign search_end = !issue && !hit;

	assign out_load = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		uniq_we     = 1'b0;
		remap_we    = 1'b0;
		remap_wdata = uniq_cnt_q[IDX_W-1:0];
		remap_raddr = cor_a_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_VERTEX: state_d = full ? S_DONE : S_SEARCH;
						MODE_TRI:    state_d = corner_bad ? S_DONE : S_TRI;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_SEARCH: begin
				if (hit) begin
					remap_we    = 1'b1;
					remap_wdata = cmp_k_q;
					state_d     = S_DONE;
				end else if (search_end) begin
					remap_we = 1'b1;
					uniq_we  = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_TRI: begin
				case (tri_step_q)
					2'd0:    remap_raddr = cor_a_q;
					2'd1:    remap_raddr = cor_b_q;
					default: remap_raddr = cor_c_q;
				endcase
				if (tri_step_q == 2'd3) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- counts and search pipe ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_cnt_q  <= '0;
			uniq_cnt_q  <= '0;
			rd_k_q      <= '0;
			cmp_valid_q <= 1'b0;
			tri_step_q  <= '0;
		end else begin
			if (accept) begin
				rd_k_q      <= '0;
				cmp_valid_q <= 1'b0;
				tri_step_q  <= '0;
				if (item.mode == MODE_BEGIN) begin
					recv_cnt_q <= '0;
					uniq_cnt_q <= '0;
				end
			end
			if (state_q == S_SEARCH) begin
				cmp_valid_q <= issue;
				if (issue) begin
					rd_k_q <= rd_k_q + CNT_W'(1);
				end
				if (remap_we) begin
					recv_cnt_q <= recv_cnt_q + CNT_W'(1);
				end
				if (uniq_we) begin
					uniq_cnt_q <= uniq_cnt_q + CNT_W'(1);
				end
			end
			if (state_q == S_TRI) begin
				tri_step_q <= tri_step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEARCH) begin
			cmp_k_q <= rd_k_q[IDX_W-1:0];
		end
	end

	// ---------------- stores ----------------
	always_ff @(posedge clk) begin
		if (uniq_we) begin
			uniq_mem[uniq_cnt_q[IDX_W-1:0]] <= crd_q;
		end
		uniq_rd_q <= uniq_mem[rd_k_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (remap_we) begin
			remap_mem[recv_cnt_q[IDX_W-1:0]] <= remap_wdata;
		end
		remap_rd_q <= remap_mem[remap_raddr];
	end

	// ---------------- result assembly ----------------
	// result seed at accept: errors answer right away, everything else zero
	always_comb begin
		acc_res = '0;
		if (item.mode == MODE_VERTEX && full) begin
			acc_res.status = ST_FULL;
		end
		if (item.mode == MODE_TRI && corner_bad) begin
			acc_res.status = ST_NO_CORNER;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			crd_q   <= '{x: item.coord_x, y: item.coord_y, z: item.coord_z};
			cor_a_q <= item.corner_a;
			cor_b_q <= item.corner_b;
			cor_c_q <= item.corner_c;
			res_q   <= acc_res;
		end
		if (state_q == S_SEARCH) begin
			if (hit) begin
				res_q.weld_index <= cmp_k_q;
				res_q.is_new     <= 1'b0;
			end else if (search_end) begin
				res_q.weld_index <= uniq_cnt_q[IDX_W-1:0];
				res_q.is_new     <= 1'b1;
			end
		end
		if (state_q == S_TRI) begin
			case (tri_step_q)
				2'd1: res_q.mapped_a <= remap_rd_q;
				2'd2: res_q.mapped_b <= remap_rd_q;
				2'd3: begin
					res_q.mapped_c      <= remap_rd_q;
					res_q.keep_triangle <= (res_q.mapped_a != res_q.mapped_b)
						&& (res_q.mapped_b != remap_rd_q)
						&& (res_q.mapped_a != remap_rd_q);
				end
				default: ;
			endcase
		end
		if (out_load) begin
			result_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	a_uniq_le_recv: assert property (@(posedge clk) disable iff (!arst_n)
		uniq_cnt_q <= recv_cnt_q)
		else $error("unique count passed received count");

	a_recv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		recv_cnt_q <= CNT_W'(MAX_VERTICES))
		else $error("received count beyond capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (rd_k_q <= uniq_cnt_q))
		else $error("search read past the unique store");

	a_keep_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.keep_triangle) |-> (result_q.status == ST_OK))
		else $error("kept triangle carries an error status");
`endif

endmodule
